@@ rtl/tqlu_pkg.sv @@
// Shared types, constants and controller/datapath interface structs for the Q-table block.
package tqlu_pkg;

   localparam int VALUE_W = 32;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   typedef logic [4:0] state_field_type;
   typedef logic signed [7:0] reward_type;
   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEARNING_RATE = 1'b0,
      CSR_DISCOUNT      = 1'b1
   } csr_index_type;

   localparam csr_data_type LEARNING_RATE_RESET = 16'd655;
   localparam csr_data_type DISCOUNT_RESET      = 16'd58982;

   localparam logic CMD_QUERY  = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic req_ready;
      logic rd_cur;
      logic cap_next;
      logic cap_cur;
      logic mul_gamma;
      logic form_diff;
      logic mul_rate;
      logic write_row;
      logic load_out;
      logic clear_step;
   } tqlu_cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic req_valid;
      logic is_update;
      logic out_free;
      logic clr_last;
   } tqlu_status_type;

endpackage

@@ rtl/tqlu_req_if.sv @@
// Request channel: command and transition fields with a valid/ready handshake.
interface tqlu_req_if;
   import tqlu_pkg::*;

   logic            valid;
   logic            ready;
   logic            command;
   state_field_type current_state;
   logic            action;
   reward_type      reward;
   state_field_type next_state;

   modport source (output valid, output command, output current_state, output action,
                   output reward, output next_state, input ready);
   modport sink   (input valid, input command, input current_state, input action,
                   input reward, input next_state, output ready);
endinterface

@@ rtl/tqlu_rsp_if.sv @@
// Response channel: greedy action and best value with a valid/ready handshake.
interface tqlu_rsp_if;
   import tqlu_pkg::*;

   logic      valid;
   logic      ready;
   logic      greedy_action;
   value_type best_value;

   modport source (output valid, output greedy_action, output best_value, input ready);
   modport sink   (input valid, input greedy_action, input best_value, output ready);
endinterface

@@ rtl/tqlu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tqlu_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tqlu_ctrl.sv @@
// Sequencer for the table clearing pass, query and read-modify-write update.
module tqlu_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  tqlu_pkg::tqlu_status_type status,
   output tqlu_pkg::tqlu_cmd_type    cmd
);
   import tqlu_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RD_CUR,
      S_LOAD_Q,
      S_MUL_GAMMA,
      S_DIFF,
      S_MUL_RATE,
      S_WRITE,
      S_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (status.req_valid) begin
               state_in = S_RD_CUR;
            end
         end
         S_RD_CUR: begin
            cmd.cap_next = 1'b1;
            cmd.rd_cur   = 1'b1;
            state_in     = status.is_update ? S_LOAD_Q : S_OUT;
         end
         S_LOAD_Q: begin
            cmd.cap_cur = 1'b1;
            state_in    = S_MUL_GAMMA;
         end
         S_MUL_GAMMA: begin
            cmd.mul_gamma = 1'b1;
            state_in      = S_DIFF;
         end
         S_DIFF: begin
            cmd.form_diff = 1'b1;
            state_in      = S_MUL_RATE;
         end
         S_MUL_RATE: begin
            cmd.mul_rate = 1'b1;
            state_in     = S_WRITE;
         end
         S_WRITE: begin
            cmd.write_row = 1'b1;
            state_in      = S_OUT;
         end
         S_OUT: begin
            // The result waits here while the previous beat is still unread.
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/tqlu_datapath.sv @@
// Datapath: request capture, table memory, fixed-point update and result register.
module tqlu_datapath #(
   parameter int NUM_STATES = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   tqlu_req_if.sink                           req,
   tqlu_rsp_if.source                         rsp,
   input  logic                               csr_wr_en,
   input  logic [tqlu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tqlu_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   input  tqlu_pkg::tqlu_cmd_type             cmd,
   output tqlu_pkg::tqlu_status_type          status
);
   import tqlu_pkg::*;

   localparam int IDX_W = $clog2(NUM_STATES);
   localparam int ROW_W = 2 * VALUE_W;

   // State indices wrap modulo the table size; the field is narrow, so a constant table.
   function automatic logic [IDX_W-1:0] wrap_state(input state_field_type s);
      logic [IDX_W-1:0] r;
      r = '0;
      for (int i = 0; i < 32; i++) begin
         if (s == 5'(i)) begin
            r = IDX_W'(i % NUM_STATES);
         end
      end
      return r;
   endfunction

   function automatic value_type row_best(input logic [ROW_W-1:0] row);
      value_type v0;
      value_type v1;
      v0 = row[VALUE_W-1:0];
      v1 = row[ROW_W-1:VALUE_W];
      return (v0 < v1) ? v1 : v0;
   endfunction

   csr_data_type learning_rate_ff;
   csr_data_type discount_ff;

   logic             cmd_ff;
   logic [IDX_W-1:0] cur_ff;
   logic             act_ff;
   reward_type       reward_ff;
   logic [IDX_W-1:0] nxt_ff;

   logic [IDX_W-1:0] clr_cnt_ff;

   logic [ROW_W-1:0] next_row_ff;
   logic [ROW_W-1:0] cur_row_ff;
   logic [ROW_W-1:0] new_row_ff;
   value_type        max_ff;
   logic signed [48:0] gamma_prod_ff;
   logic signed [34:0] diff_ff;
   logic signed [51:0] rate_prod_ff;

   logic      rsp_valid_ff;
   logic      rsp_greedy_ff;
   value_type rsp_best_ff;

   logic             accept;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   logic [ROW_W-1:0] wr_data;
   logic             wr_en;
   logic [ROW_W-1:0] rd_data;

   value_type          q_old;
   logic signed [34:0] reward_ext;
   logic signed [34:0] gamma_ext;
   logic signed [34:0] q_ext;
   logic signed [34:0] diff_in;
   logic signed [36:0] sum_q;
   value_type          q_new;
   logic [ROW_W-1:0]   new_row;
   logic [ROW_W-1:0]   query_row;
   value_type          qv0;
   value_type          qv1;

   assign accept    = cmd.req_ready & req.valid;
   assign req.ready = cmd.req_ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         learning_rate_ff <= LEARNING_RATE_RESET;
         discount_ff      <= DISCOUNT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_LEARNING_RATE: learning_rate_ff <= csr_wr_data;
            CSR_DISCOUNT:      discount_ff      <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req.command;
         cur_ff    <= wrap_state(req.current_state);
         act_ff    <= req.action;
         reward_ff <= req.reward;
         nxt_ff    <= wrap_state(req.next_state);
      end
   end

   // Clearing pass counter, one row per cycle after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // Row layout: action 1 in the upper half, action 0 in the lower half.
   assign rd_addr = cmd.rd_cur ? cur_ff : wrap_state(req.next_state);
   assign wr_en   = cmd.clear_step | cmd.write_row;
   assign wr_addr = cmd.clear_step ? clr_cnt_ff : cur_ff;
   assign wr_data = cmd.clear_step ? '0 : new_row;

   tqlu_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_STATES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept | cmd.rd_cur),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign q_old      = act_ff ? cur_row_ff[ROW_W-1:VALUE_W] : cur_row_ff[VALUE_W-1:0];
   assign reward_ext = {{11{reward_ff[7]}}, reward_ff, 16'h0000};
   // An arithmetic shift by 16 rounds toward minus infinity.
   assign gamma_ext  = {{2{gamma_prod_ff[48]}}, gamma_prod_ff[48:16]};
   assign q_ext      = {{3{q_old[VALUE_W-1]}}, q_old};
   assign diff_in    = reward_ext + gamma_ext - q_ext;
   assign sum_q      = {{5{q_old[VALUE_W-1]}}, q_old} + {rate_prod_ff[51], rate_prod_ff[51:16]};

   always_comb begin
      if (!sum_q[36] && (|sum_q[35:31])) begin
         q_new = {1'b0, {(VALUE_W-1){1'b1}}};
      end else if (sum_q[36] && !(&sum_q[35:31])) begin
         q_new = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         q_new = sum_q[VALUE_W-1:0];
      end
      if (act_ff) begin
         new_row = {q_new, cur_row_ff[VALUE_W-1:0]};
      end else begin
         new_row = {cur_row_ff[ROW_W-1:VALUE_W], q_new};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_next) begin
         next_row_ff <= rd_data;
      end
      if (cmd.cap_cur) begin
         cur_row_ff <= rd_data;
         max_ff     <= row_best(next_row_ff);
      end
      if (cmd.mul_gamma) begin
         gamma_prod_ff <= $signed({1'b0, discount_ff}) * max_ff;
      end
      if (cmd.form_diff) begin
         diff_ff <= diff_in;
      end
      if (cmd.mul_rate) begin
         rate_prod_ff <= $signed({1'b0, learning_rate_ff}) * diff_ff;
      end
      if (cmd.write_row) begin
         new_row_ff <= new_row;
      end
   end

   // When the updated row is also the queried one, the query sees the new value.
   assign query_row = (cmd_ff == CMD_UPDATE && cur_ff == nxt_ff) ? new_row_ff : next_row_ff;
   assign qv0       = query_row[VALUE_W-1:0];
   assign qv1       = query_row[ROW_W-1:VALUE_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_greedy_ff <= (qv0 > qv1) ? 1'b0 : 1'b1;
         rsp_best_ff   <= (qv0 < qv1) ? qv1 : qv0;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.greedy_action = rsp_greedy_ff;
   assign rsp.best_value    = rsp_best_ff;

   assign status.req_valid = req.valid;
   assign status.is_update = (cmd_ff == CMD_UPDATE);
   assign status.out_free  = !rsp_valid_ff || rsp.ready;
   assign status.clr_last  = (clr_cnt_ff == IDX_W'(NUM_STATES - 1));

endmodule

@@ rtl/tabular_q_learning_update_top.sv @@
// Top level of the two-action tabular Q-learning update block.
// The block takes one request beat at a time. A query reads the row of the next state and
// loads the output register; an update steps through two table reads, the gamma and
// learning-rate multiplies (each registered), the difference add and the saturating
// write-back before it loads the output register, and the next request is accepted once the
// result has been loaded. The result register holds one finished beat, so a new request
// is taken while it waits; a later result waits in its last step until the previous beat has
// been read. After reset the table is cleared one state per cycle, during which no request
// is accepted; configuration writes are taken at any time. State indices wrap modulo
// NUM_STATES.
module tabular_q_learning_update_top #(
   parameter int NUM_STATES = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   tqlu_req_if.sink                        req,
   tqlu_rsp_if.source                      rsp,
   input  logic                            csr_wr_en,
   input  logic [tqlu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tqlu_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import tqlu_pkg::*;

   tqlu_cmd_type    cmd;
   tqlu_status_type status;

   tqlu_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   tqlu_datapath #(
      .NUM_STATES (NUM_STATES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

@@ rtl/tqlu_checker.sv @@
// Port-level checker for the Q-table block and its bind to the top level.
module tqlu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_greedy_action,
   input logic [31:0] rsp_best_value
);

   // A waiting result beat is neither dropped nor altered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_best_value)
         && $stable(rsp_greedy_action))
      else $error("rsp beat changed or dropped while stalled");

   // One item at a time: ready drops straight after a request beat.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while an item is in flight");

   // A new result appears only out of the final step, where no request is taken.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while the block was idle");

   // The clearing pass keeps requests out straight after reset.
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_ready)
      else $error("request ready during table clearing");

endmodule

bind tabular_q_learning_update_top tqlu_checker u_tqlu_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_greedy_action (rsp.greedy_action),
   .rsp_best_value    (rsp.best_value)
);

@@ tb/tb_tabular_q_learning_update_top.sv @@
// Self-checking testbench for the two-action tabular Q-learning update block.
module tb_tabular_q_learning_update_top;
   import tqlu_pkg::*;

   localparam int NUM_STATES    = 32;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES   = 200;
   localparam int REPORT_LIMIT  = 10;
   localparam longint VALUE_MAX = 64'sd2147483647;
   localparam longint VALUE_MIN = -64'sd2147483648;

   typedef struct {
      logic            command;
      state_field_type current_state;
      logic            action;
      reward_type      reward;
      state_field_type next_state;
   } transition_type;

   typedef struct {
      logic      greedy_action;
      value_type best_value;
   } greedy_result_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   csr_data_type         csr_wr_data;

   tqlu_req_if req_ch ();
   tqlu_rsp_if rsp_ch ();

   tabular_q_learning_update_top #(.NUM_STATES(NUM_STATES)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Predicted contents of the action-value table and the two step-size registers.
   value_type         q_table [NUM_STATES][2];
   csr_data_type      model_learning_rate;
   csr_data_type      model_discount;
   greedy_result_type pending_greedy_results [$];

   int mismatches    = 0;
   int results_seen  = 0;
   int cycle_count   = 0;
   int hold_requests = 0;
   bit gaps_on       = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic clear_value_model();
      for (int s = 0; s < NUM_STATES; s++) begin
         q_table[s][0] = '0;
         q_table[s][1] = '0;
      end
      model_learning_rate = LEARNING_RATE_RESET;
      model_discount      = DISCOUNT_RESET;
   endtask

   function automatic greedy_result_type predict_greedy_result(input transition_type t);
      int unsigned       cur;
      int unsigned       nxt;
      longint            q_old;
      longint            best_next;
      longint            target;
      longint            q_new;
      value_type         v0;
      value_type         v1;
      greedy_result_type res;
      cur = t.current_state % NUM_STATES;
      nxt = t.next_state % NUM_STATES;
      if (t.command == CMD_UPDATE) begin
         q_old     = q_table[cur][t.action];
         v0        = q_table[nxt][0];
         v1        = q_table[nxt][1];
         best_next = (v0 < v1) ? v1 : v0;
         // Both products are floored, which an arithmetic shift of the 64-bit value gives.
         target = longint'(t.reward) * 65536
                  + ((longint'(model_discount) * best_next) >>> 16);
         q_new  = q_old + ((longint'(model_learning_rate) * (target - q_old)) >>> 16);
         if (q_new > VALUE_MAX) begin
            q_new = VALUE_MAX;
         end else if (q_new < VALUE_MIN) begin
            q_new = VALUE_MIN;
         end
         q_table[cur][t.action] = value_type'(q_new);
      end
      v0 = q_table[nxt][0];
      v1 = q_table[nxt][1];
      res.greedy_action = (v0 > v1) ? 1'b0 : 1'b1;
      res.best_value    = (v0 < v1) ? v1 : v0;
      return res;
   endfunction

   function automatic state_field_type pick_state();
      // A small pool of states makes chains of updates revisit the same entries.
      if ($urandom_range(0, 99) < 60) begin
         return state_field_type'($urandom_range(0, 7));
      end
      return state_field_type'($urandom_range(0, 31));
   endfunction

   function automatic transition_type random_transition();
      transition_type t;
      t.command       = ($urandom_range(0, 99) < 75) ? CMD_UPDATE : CMD_QUERY;
      t.current_state = pick_state();
      t.next_state    = ($urandom_range(0, 99) < 20) ? t.current_state : pick_state();
      t.action        = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         0: begin
            t.reward = reward_type'(127);
         end
         1: begin
            t.reward = reward_type'(-128);
         end
         default: begin
            t.reward = reward_type'($urandom_range(0, 255));
         end
      endcase
      return t;
   endfunction

   // Offers one request beat and predicts its result once it has been taken.
   // Valid is left high so that a following beat can go out back to back.
   task automatic send_transition(input transition_type t);
      while (gaps_on && $urandom_range(0, 99) < 25) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.command       <= t.command;
      req_ch.current_state <= t.current_state;
      req_ch.action        <= t.action;
      req_ch.reward        <= t.reward;
      req_ch.next_state    <= t.next_state;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_greedy_results.push_back(predict_greedy_result(t));
   endtask

   task automatic send_fields(input logic cmd, input int cur, input logic act, input int rew,
                              input int nxt);
      transition_type t;
      t.command       = cmd;
      t.current_state = state_field_type'(cur);
      t.action        = act;
      t.reward        = reward_type'(rew);
      t.next_state    = state_field_type'(nxt);
      send_transition(t);
   endtask

   task automatic wait_for_idle();
      req_ch.valid <= 1'b0;
      while (pending_greedy_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input csr_data_type data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      if (idx == CSR_LEARNING_RATE) begin
         model_learning_rate = data;
      end else begin
         model_discount = data;
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_step_sizes(input csr_data_type rate, input csr_data_type gamma);
      wait_for_idle();
      write_register(CSR_LEARNING_RATE, rate);
      write_register(CSR_DISCOUNT, gamma);
   endtask

   // Result side: checks every beat against the oldest prediction and drives ready.
   initial begin : rsp_sink
      int                hold_left;
      int                holds_served;
      greedy_result_type want;
      hold_left    = 0;
      holds_served = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            results_seen++;
            if (pending_greedy_results.size() == 0) begin
               if (mismatches < REPORT_LIMIT) begin
                  $display("result %0d: unexpected beat, greedy %0b value %0d", results_seen,
                           rsp_ch.greedy_action, rsp_ch.best_value);
               end
               mismatches++;
            end else begin
               want = pending_greedy_results.pop_front();
               if (rsp_ch.greedy_action !== want.greedy_action ||
                   rsp_ch.best_value !== want.best_value) begin
                  if (mismatches < REPORT_LIMIT) begin
                     $display("result %0d: expected greedy %0b value %0d, got greedy %0b value %0d",
                              results_seen, want.greedy_action, want.best_value,
                              rsp_ch.greedy_action, rsp_ch.best_value);
                  end
                  mismatches++;
               end
            end
         end
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !(gaps_on && $urandom_range(0, 99) < 25);
         end
      end
   end

   task automatic test_reset_state();
      send_fields(CMD_QUERY, 0, 1'b0, 0, 0);
      send_fields(CMD_QUERY, 31, 1'b1, -128, 31);
      send_fields(CMD_QUERY, 17, 1'b0, 127, 12);
   endtask

   task automatic test_directed_updates();
      send_fields(CMD_UPDATE, 0, 1'b0, 127, 31);
      send_fields(CMD_UPDATE, 31, 1'b1, -128, 0);
      send_fields(CMD_QUERY, 5, 1'b1, -1, 0);
      send_fields(CMD_QUERY, 0, 1'b0, 0, 31);
      // With the same state on both sides the maximum is taken before the write.
      send_fields(CMD_UPDATE, 5, 1'b1, 100, 5);
      send_fields(CMD_UPDATE, 5, 1'b0, 100, 5);
      send_fields(CMD_UPDATE, 5, 1'b0, -1, 5);
      set_step_sizes(16'hFFFF, 16'hFFFF);
      send_fields(CMD_UPDATE, 0, 1'b1, 127, 0);
      send_fields(CMD_UPDATE, 0, 1'b0, -128, 0);
      send_fields(CMD_UPDATE, 31, 1'b0, 0, 0);
      set_step_sizes(16'h0000, 16'hFFFF);
      send_fields(CMD_UPDATE, 0, 1'b1, -128, 5);
      set_step_sizes(16'hFFFF, 16'h0000);
      send_fields(CMD_UPDATE, 31, 1'b1, 127, 31);
      send_fields(CMD_UPDATE, 5, 1'b0, -128, 0);
      set_step_sizes(LEARNING_RATE_RESET, DISCOUNT_RESET);
      send_fields(CMD_UPDATE, 12, 1'b1, 64, 5);
   endtask

   // Full step and discount on a self loop drive one value to each end of the range.
   task automatic test_saturation();
      set_step_sizes(16'hFFFF, 16'hFFFF);
      for (int i = 0; i < 300; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_fields(CMD_QUERY, $urandom_range(0, 31), 1'($urandom_range(0, 1)),
                        $urandom_range(0, 255), $urandom_range(0, 31));
         end
         send_fields(CMD_UPDATE, 30, 1'b0, 127, 30);
      end
      // Both actions must fall together, or the maximum holds the target up.
      for (int i = 0; i < 560; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_transition(random_transition());
         end
         send_fields(CMD_UPDATE, 29, i[0], -128, 29);
      end
   endtask

   task automatic test_input_stall();
      set_step_sizes(csr_data_type'($urandom_range(0, 65535)),
                     csr_data_type'($urandom_range(0, 65535)));
      gaps_on       <= 1'b0;
      hold_requests <= hold_requests + 1;
      for (int i = 0; i < 40; i++) begin
         send_transition(random_transition());
      end
      gaps_on <= 1'b1;
   endtask

   task automatic test_random_settings();
      csr_data_type rate;
      csr_data_type gamma;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1: begin
               rate  = 16'hFFFF;
               gamma = 16'h0000;
            end
            2: begin
               rate  = 16'h0000;
               gamma = 16'hFFFF;
            end
            3: begin
               rate  = LEARNING_RATE_RESET;
               gamma = DISCOUNT_RESET;
            end
            5: begin
               rate  = 16'h8000;
               gamma = 16'h8000;
            end
            default: begin
               rate  = csr_data_type'($urandom_range(0, 65535));
               gamma = csr_data_type'($urandom_range(0, 65535));
            end
         endcase
         set_step_sizes(rate, gamma);
         // One phase runs with both sides always willing.
         gaps_on <= (phase != 3);
         for (int i = 0; i < 70; i++) begin
            send_transition(random_transition());
         end
      end
      gaps_on <= 1'b1;
   endtask

   initial begin : stimulus
      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_index            <= CSR_LEARNING_RATE;
      csr_wr_data          <= '0;
      req_ch.valid         <= 1'b0;
      req_ch.command       <= CMD_QUERY;
      req_ch.current_state <= '0;
      req_ch.action        <= 1'b0;
      req_ch.reward        <= '0;
      req_ch.next_state    <= '0;
      clear_value_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_directed_updates();
      test_saturation();
      test_input_stall();
      test_random_settings();
      wait_for_idle();
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
